### src/lpr_pkg.sv
// Shared types and constants for the LRU page-replacement tracker.
`default_nettype none

package lpr_pkg;

    // Fixed widths of the channel fields.
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned PAGE_W   = 16;
    localparam int unsigned FIDX_W   = 4;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned STAMP_W  = 32;

    // Reset value of the frame count register.
    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd3;

    // Saturation value of the reference clock and both counters.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_EMIT
    } lpr_state_t;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;   // a new reference starts, drop the previous scan results
        logic step;    // read data for one frame is present this cycle
    } lpr_scan_ctl_t;

endpackage

`default_nettype wire

### src/lpr_frame_mem.sv
// Frame table memory: one write port, one read port with registered read data.
`default_nettype none

module lpr_frame_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/lpr_scan.sv
// Scan unit: walks the frame entries, one per cycle while step is set, for match, free slot and oldest stamp.
`default_nettype none

module lpr_scan #(
    parameter int unsigned IW = 4,
    parameter int unsigned SW = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lpr_pkg::lpr_scan_ctl_t        ctl,
    input  wire logic [IW-1:0]                 idx,
    input  wire logic                          entry_valid,
    input  wire logic [SW-1:0]                 entry_page,
    input  wire logic [lpr_pkg::STAMP_W-1:0]   entry_stamp,
    input  wire logic [SW-1:0]                 key,
    output logic                               found,
    output logic [IW-1:0]                      match_idx,
    output logic                               free_found,
    output logic [IW-1:0]                      free_idx,
    output logic [IW-1:0]                      min_idx,
    output logic [SW-1:0]                      min_page
);

    logic                          found_reg,      found_next;
    logic                          free_found_reg, free_found_next;
    logic                          have_min_reg,   have_min_next;
    logic [IW-1:0]                 match_idx_reg,  match_idx_next;
    logic [IW-1:0]                 free_idx_reg,   free_idx_next;
    logic [IW-1:0]                 min_idx_reg,    min_idx_next;
    logic [SW-1:0]                 min_page_reg,   min_page_next;
    logic [lpr_pkg::STAMP_W-1:0]   min_stamp_reg,  min_stamp_next;

    always_comb begin
        found_next      = found_reg;
        free_found_next = free_found_reg;
        have_min_next   = have_min_reg;
        match_idx_next  = match_idx_reg;
        free_idx_next   = free_idx_reg;
        min_idx_next    = min_idx_reg;
        min_page_next   = min_page_reg;
        min_stamp_next  = min_stamp_reg;
        if (ctl.clear) begin
            found_next      = 1'b0;
            free_found_next = 1'b0;
            have_min_next   = 1'b0;
        end else if (ctl.step) begin
            // Only the lowest-indexed match and free frame count.
            if (!found_reg && entry_valid && entry_page == key) begin
                found_next     = 1'b1;
                match_idx_next = idx;
            end
            if (!free_found_reg && !entry_valid) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
            end
            // Strict compare keeps the lowest index on equal stamps.
            if (!have_min_reg || entry_stamp < min_stamp_reg) begin
                have_min_next  = 1'b1;
                min_idx_next   = idx;
                min_page_next  = entry_page;
                min_stamp_next = entry_stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            have_min_reg   <= 1'b0;
        end else begin
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            have_min_reg   <= have_min_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        min_idx_reg   <= min_idx_next;
        min_page_reg  <= min_page_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign found      = found_reg;
    assign match_idx  = match_idx_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign min_idx    = min_idx_reg;
    assign min_page   = min_page_reg;

endmodule

`default_nettype wire

### src/lru_page_replacement.sv
// Top level of the LRU page-replacement tracker: sequencer, counters and output register.
`default_nettype none

// Each accepted reference passes from input transfer to a result in the output register
// through the sequencer states SCAN, LAST, UPDATE and EMIT: the
// frame table sits in a single-port-read memory that is scanned one entry per cycle,
// followed by the read latency in LAST, the write-back in UPDATE and the load of the
// output register in EMIT. A new reference is taken in the cycle after its
// predecessor's result is loaded, even if that result has not yet been
// transferred. A frame count of 0 acts as 1 and values above FRAMES act as FRAMES;
// it must only be written while no reference is in flight. A reference with
// last_ref set returns its result normally and then empties all frames and
// clears the reference clock and both totals. No clearing pass is needed
// after reset.
module lru_page_replacement #(
    parameter int unsigned FRAMES    = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lpr_pkg::CFG_W-1:0]      cfg_frame_count,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lpr_pkg::PAGE_W-1:0]     s_page,
    input  wire logic                           s_last_ref,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_hit,
    output logic [lpr_pkg::FIDX_W-1:0]          m_frame_index,
    output logic                                m_evicted_valid,
    output logic [lpr_pkg::PAGE_W-1:0]          m_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]         m_hit_total,
    output logic [lpr_pkg::COUNT_W-1:0]         m_fault_total
);

    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned CW = $clog2(FRAMES + 1);
    // Pages never exceed the input field, so wider settings add only zeros.
    localparam int unsigned SW = (PAGE_BITS < lpr_pkg::PAGE_W) ? PAGE_BITS : lpr_pkg::PAGE_W;
    localparam int unsigned DW = SW + lpr_pkg::STAMP_W;

    lpr_pkg::lpr_state_t state_reg, state_next;

    logic [lpr_pkg::CFG_W-1:0]   frame_count_reg;
    logic [CW-1:0]               n_active;
    logic [CW-1:0]               n_reg;
    logic [SW-1:0]               key_reg;
    logic                        last_reg;
    logic [lpr_pkg::COUNT_W-1:0] ref_clock_reg, ref_clock_next;
    logic [lpr_pkg::COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic [lpr_pkg::COUNT_W-1:0] fault_count_reg, fault_count_next;
    logic [FRAMES-1:0]           valid_reg;
    logic [IW-1:0]               rd_addr_reg;
    logic                        cmp_valid_reg;
    logic [IW-1:0]               cmp_idx_reg;

    logic                        in_xfer;
    logic                        rd_en;
    logic                        last_issue;
    logic                        do_update;
    logic                        emit_load;
    lpr_pkg::lpr_scan_ctl_t      scan_ctl;

    logic [DW-1:0]               rd_data;
    logic                        sc_found;
    logic [IW-1:0]               sc_match_idx;
    logic                        sc_free_found;
    logic [IW-1:0]               sc_free_idx;
    logic [IW-1:0]               sc_min_idx;
    logic [SW-1:0]               sc_min_page;
    logic [IW-1:0]               slot;
    logic                        evict;

    logic                        res_hit_reg;
    logic [IW-1:0]               res_idx_reg;
    logic                        res_evv_reg;
    logic [SW-1:0]               res_evp_reg;
    logic [lpr_pkg::COUNT_W-1:0] res_hits_reg;
    logic [lpr_pkg::COUNT_W-1:0] res_faults_reg;

    logic                        m_valid_reg;

    // Configuration register: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= lpr_pkg::FRAME_COUNT_RESET;
        end else if (cfg_valid) begin
            frame_count_reg <= cfg_frame_count;
        end
    end

    always_comb begin
        if (frame_count_reg == '0) begin
            n_active = CW'(1);
        end else if (32'(frame_count_reg) > 32'(FRAMES)) begin
            n_active = CW'(FRAMES);
        end else begin
            n_active = CW'(frame_count_reg);
        end
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lpr_pkg::ST_SCAN;
                end
            end
            lpr_pkg::ST_SCAN: begin
                if (last_issue) begin
                    state_next = lpr_pkg::ST_LAST;
                end
            end
            lpr_pkg::ST_LAST:   state_next = lpr_pkg::ST_UPDATE;
            lpr_pkg::ST_UPDATE: state_next = lpr_pkg::ST_EMIT;
            lpr_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default: state_next = lpr_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        do_update = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            lpr_pkg::ST_IDLE:   s_ready   = 1'b1;
            lpr_pkg::ST_SCAN:   rd_en     = 1'b1;
            lpr_pkg::ST_LAST:   rd_en     = 1'b0;
            lpr_pkg::ST_UPDATE: do_update = 1'b1;
            lpr_pkg::ST_EMIT:   emit_load = !m_valid_reg || m_ready;
            default:            s_ready   = 1'b0;
        endcase
    end

    assign in_xfer        = s_valid && s_ready;
    assign last_issue     = (CW'(rd_addr_reg) + CW'(1)) == n_reg;
    assign scan_ctl.clear = in_xfer;
    assign scan_ctl.step  = cmp_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpr_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr_reg;
        if (in_xfer) begin
            key_reg     <= SW'(s_page);
            last_reg    <= s_last_ref;
            n_reg       <= n_active;
            rd_addr_reg <= '0;
        end else if (rd_en) begin
            rd_addr_reg <= rd_addr_reg + IW'(1);
        end
    end

    lpr_frame_mem #(
        .DEPTH (FRAMES),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (do_update),
        .waddr (slot),
        .wdata ({key_reg, ref_clock_reg}),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (rd_data)
    );

    lpr_scan #(
        .IW (IW),
        .SW (SW)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .idx         (cmp_idx_reg),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .entry_page  (rd_data[DW-1 -: SW]),
        .entry_stamp (rd_data[lpr_pkg::STAMP_W-1:0]),
        .key         (key_reg),
        .found       (sc_found),
        .match_idx   (sc_match_idx),
        .free_found  (sc_free_found),
        .free_idx    (sc_free_idx),
        .min_idx     (sc_min_idx),
        .min_page    (sc_min_page)
    );

    assign evict = !sc_found && !sc_free_found;

    always_comb begin
        if (sc_found) begin
            slot = sc_match_idx;
        end else if (sc_free_found) begin
            slot = sc_free_idx;
        end else begin
            slot = sc_min_idx;
        end
    end

    // Clock ticks when a reference is taken; counters move at write-back.
    always_comb begin
        ref_clock_next   = ref_clock_reg;
        hit_count_next   = hit_count_reg;
        fault_count_next = fault_count_reg;
        if (in_xfer && ref_clock_reg != lpr_pkg::COUNT_MAX) begin
            ref_clock_next = ref_clock_reg + lpr_pkg::COUNT_W'(1);
        end
        if (do_update) begin
            if (sc_found && hit_count_reg != lpr_pkg::COUNT_MAX) begin
                hit_count_next = hit_count_reg + lpr_pkg::COUNT_W'(1);
            end
            if (!sc_found && fault_count_reg != lpr_pkg::COUNT_MAX) begin
                fault_count_next = fault_count_reg + lpr_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clock_reg   <= '0;
            hit_count_reg   <= '0;
            fault_count_reg <= '0;
            valid_reg       <= '0;
        end else if (do_update && last_reg) begin
            // The result has been captured below, so the string can end here.
            ref_clock_reg   <= '0;
            hit_count_reg   <= '0;
            fault_count_reg <= '0;
            valid_reg       <= '0;
        end else begin
            ref_clock_reg   <= ref_clock_next;
            hit_count_reg   <= hit_count_next;
            fault_count_reg <= fault_count_next;
            if (do_update) begin
                valid_reg[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            res_hit_reg    <= sc_found;
            res_idx_reg    <= slot;
            res_evv_reg    <= evict;
            res_evp_reg    <= evict ? sc_min_page : '0;
            res_hits_reg   <= hit_count_next;
            res_faults_reg <= fault_count_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_hit           <= res_hit_reg;
            m_frame_index   <= lpr_pkg::FIDX_W'(res_idx_reg);
            m_evicted_valid <= res_evv_reg;
            m_evicted_page  <= lpr_pkg::PAGE_W'(res_evp_reg);
            m_hit_total     <= res_hits_reg;
            m_fault_total   <= res_faults_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // A last reference leaves every frame empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_update && last_reg) |=> (valid_reg == '0))
        else $error("frames not emptied after last reference");

    // A hit never reports an eviction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_update |=> !(res_hit_reg && res_evv_reg))
        else $error("hit and eviction reported together");

    // The clock has ticked before any frame is scanned, so new stamps are never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lpr_pkg::ST_SCAN) |-> (ref_clock_reg != '0))
        else $error("reference clock did not tick");

    // The output register is only loaded when its previous result has left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_hit_total) && $stable(m_frame_index))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the LRU page-replacement tracker, with a built-in predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CFG_W   = lpr_pkg::CFG_W;
    localparam int unsigned PAGE_W  = lpr_pkg::PAGE_W;
    localparam int unsigned FIDX_W  = lpr_pkg::FIDX_W;
    localparam int unsigned COUNT_W = lpr_pkg::COUNT_W;
    localparam int unsigned STAMP_W = lpr_pkg::STAMP_W;
    localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = lpr_pkg::FRAME_COUNT_RESET;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = lpr_pkg::COUNT_MAX;

    localparam int unsigned NFRAMES      = 16;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_REFS   = 63;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last;
    } page_ref_t;

    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] faults;
    } ref_result_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_frame_count = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [PAGE_W-1:0]   s_page          = '0;
    logic                s_last_ref      = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_hit;
    logic [FIDX_W-1:0]   m_frame_index;
    logic                m_evicted_valid;
    logic [PAGE_W-1:0]   m_evicted_page;
    logic [COUNT_W-1:0]  m_hit_total;
    logic [COUNT_W-1:0]  m_fault_total;

    int unsigned send_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;

    page_ref_t   pending_refs[$];
    ref_result_t expected_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Predictor copy of the tracker state.
    logic [CFG_W-1:0]   frames_cfg = FRAME_COUNT_RESET;
    logic [PAGE_W-1:0]  frame_page  [NFRAMES];
    logic               frame_used  [NFRAMES];
    logic [STAMP_W-1:0] frame_stamp [NFRAMES];
    logic [STAMP_W-1:0] ref_clock;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;

    lru_page_replacement u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_frame_count (cfg_frame_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page          (s_page),
        .s_last_ref      (s_last_ref),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_hit_total     (m_hit_total),
        .m_fault_total   (m_fault_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_tracker();
        for (int f = 0; f < NFRAMES; f++) begin
            frame_page[f]  = '0;
            frame_used[f]  = 1'b0;
            frame_stamp[f] = '0;
        end
        ref_clock   = '0;
        hit_count   = '0;
        fault_count = '0;
    endfunction

    // Applies one page reference to the predictor state and returns its result.
    function automatic ref_result_t lru_access(page_ref_t r);
        ref_result_t res;
        int unsigned n;
        int unsigned slot;
        bit          found;
        bit          free_found;
        res        = '0;
        found      = 1'b0;
        free_found = 1'b0;
        slot       = 0;
        if (frames_cfg == 0)
            n = 1;
        else if (frames_cfg > NFRAMES)
            n = NFRAMES;
        else
            n = frames_cfg;
        if (ref_clock != COUNT_MAX) ref_clock++;
        for (int f = 0; f < n; f++) begin
            if (!found && frame_used[f] && frame_page[f] == r.page) begin
                slot  = f;
                found = 1'b1;
            end
        end
        if (found) begin
            if (hit_count != COUNT_MAX) hit_count++;
            frame_stamp[slot] = ref_clock;
        end else begin
            if (fault_count != COUNT_MAX) fault_count++;
            for (int f = 0; f < n; f++) begin
                if (!free_found && !frame_used[f]) begin
                    slot       = f;
                    free_found = 1'b1;
                end
            end
            if (!free_found) begin
                // Oldest stamp loses; the strict compare keeps the lowest index on ties.
                slot = 0;
                for (int f = 1; f < n; f++)
                    if (frame_stamp[f] < frame_stamp[slot]) slot = f;
                res.evicted      = 1'b1;
                res.evicted_page = frame_page[slot];
            end
            frame_page[slot]  = r.page;
            frame_used[slot]  = 1'b1;
            frame_stamp[slot] = ref_clock;
        end
        res.hit    = found;
        res.frame  = slot[FIDX_W-1:0];
        res.hits   = hit_count;
        res.faults = fault_count;
        if (r.last) clear_tracker();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Reference driver: offers the oldest pending reference and predicts it on transfer.
    always @(posedge aclk) begin
        logic offer;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(lru_access(pending_refs.pop_front()));
            end
            offer = s_valid && !s_ready;
            if (!offer && pending_refs.size() != 0)
                offer = ($urandom_range(99) >= send_gap_pct);
            s_valid <= offer;
            if (offer) begin
                s_page     <= pending_refs[0].page;
                s_last_ref <= pending_refs[0].last;
            end
        end
    end

    // Result monitor: compares each transfer with the oldest prediction.
    always @(posedge aclk) begin
        ref_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit=%0d frame=%0d",
                         $time, m_hit, m_frame_index);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", want.hit, m_hit);
                check_field("frame_index", want.frame, m_frame_index);
                check_field("evicted_valid", want.evicted, m_evicted_valid);
                check_field("evicted_page", want.evicted_page, m_evicted_page);
                check_field("hit_total", want.hits, m_hit_total);
                check_field("fault_total", want.faults, m_fault_total);
            end
        end
        if (rx_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void add_ref(input logic [PAGE_W-1:0] page, input logic last);
        page_ref_t r;
        r.page = page;
        r.last = last;
        pending_refs.push_back(r);
    endfunction

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_refs.size() != 0 || expected_results.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        cfg_frame_count <= value;
        cfg_valid       <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        frames_cfg = value;
    endtask

    // Queues reference strings drawn mostly from a small page pool so that hits and
    // evictions are frequent. A string cut off by the end of the phase stays open
    // across the next frame-count change.
    task automatic queue_strings(input int unsigned count, input int unsigned nf);
        logic [PAGE_W-1:0] pool [20];
        logic [PAGE_W-1:0] page;
        int unsigned pool_n;
        int unsigned len;
        int unsigned done;
        int unsigned roll;
        bit          close_string;
        done = 0;
        while (done < count) begin
            pool_n = $urandom_range(nf + 4, 1);
            for (int i = 0; i < pool_n; i++)
                pool[i] = ($urandom_range(3) == 0) ? PAGE_W'($urandom_range(15))
                                                   : PAGE_W'($urandom_range(16'hFFFF));
            len          = $urandom_range(40, 4);
            close_string = ($urandom_range(3) != 0);
            for (int k = 0; k < len && done < count; k++) begin
                roll = $urandom_range(99);
                if (roll < 88)
                    page = pool[$urandom_range(pool_n - 1)];
                else
                    page = PAGE_W'($urandom_range(16'hFFFF));
                add_ref(page, (close_string && k == len - 1) || roll >= 96);
                done++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] nf_cfg;
        int unsigned      nf;
        clear_tracker();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset frame count of three: free fills, two hits, two LRU evictions, field extremes.
        add_ref(16'h0000, 1'b0);
        add_ref(16'hFFFF, 1'b0);
        add_ref(16'h1234, 1'b0);
        add_ref(16'h0000, 1'b0);
        add_ref(16'h5678, 1'b0);
        add_ref(16'hFFFF, 1'b0);
        add_ref(16'h5678, 1'b1);
        wait_drained();

        // A frame count of zero behaves as one frame.
        write_frame_count(5'd0);
        add_ref(16'h0007, 1'b0);
        add_ref(16'h0007, 1'b0);
        add_ref(16'h0009, 1'b0);
        add_ref(16'h0009, 1'b1);
        wait_drained();

        // Counts above the table size are clamped to sixteen frames.
        write_frame_count(5'd31);
        add_ref(16'h8000, 1'b0);
        add_ref(16'h4000, 1'b0);
        add_ref(16'h8000, 1'b1);
        wait_drained();

        // Frame count changed within one string: inactive frames keep their pages.
        write_frame_count(5'd2);
        add_ref(16'h000A, 1'b0);
        add_ref(16'h000B, 1'b0);
        add_ref(16'h000C, 1'b0);
        wait_drained();
        write_frame_count(5'd4);
        add_ref(16'h000B, 1'b0);
        add_ref(16'h000A, 1'b0);
        add_ref(16'h000D, 1'b0);
        wait_drained();
        write_frame_count(5'd1);
        add_ref(16'h000C, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       nf_cfg = 5'd16;
                1:       nf_cfg = 5'd1;
                2:       nf_cfg = 5'd31;
                3:       nf_cfg = 5'd0;
                4:       nf_cfg = 5'd17;
                5:       nf_cfg = 5'd4;
                6:       nf_cfg = 5'd2;
                7:       nf_cfg = 5'd8;
                default: nf_cfg = CFG_W'($urandom_range(31));
            endcase
            if (nf_cfg == 0)
                nf = 1;
            else if (nf_cfg > NFRAMES)
                nf = NFRAMES;
            else
                nf = nf_cfg;
            write_frame_count(nf_cfg);
            case (p % 4)
                0: begin send_gap_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin send_gap_pct <= 51; rx_stall_pct <= 0;  end
                2: begin send_gap_pct <= 0;  rx_stall_pct <= 51; end
                default: begin send_gap_pct <= 6; rx_stall_pct <= 6; end
            endcase
            queue_strings(PHASE_REFS, nf);
            if (p == 0) begin
                // Output held off while the sender keeps offering, so the block backs up.
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
